@@ src/lz78_phrase_decoder_unit_assert.svh @@
// Assertion macros for the LZ78 phrase decoder.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LZ78_PHRASE_DECODER_UNIT_ASSERT_SVH
`define LZ78_PHRASE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LZD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lzd assertion failed");
`define LZD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lzd forbidden condition seen");
`else
`define LZD_ASSERT(lbl, clk, rst_n, prop)
`define LZD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ src/lzd_pkg.sv @@
// Shared types and constants of the LZ78 phrase decoder.
// No dependencies; used by lzd_front, lzd_back and the top level.
`default_nettype none
package lzd_pkg;
    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int MAX_PHRASE_DEF   = 64;
    localparam int IDX_W            = 16;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 7;
    localparam int ST_W             = 2;
    localparam int IN_TDATA_W       = 24;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_TOO_LONG  = 2'd3;

    typedef struct packed {
        logic              start_new;
        logic              idx_zero;
        logic [IDX_W-1:0]  phrase_index;
        logic [BYTE_W-1:0] literal;
    } t_token;
endpackage
`default_nettype wire

@@ src/lzd_front.sv @@
// Token intake: unpacks and classifies input items into a short queue.
// Depends on lzd_pkg and the assertion macro header.
`default_nettype none
`include "lz78_phrase_decoder_unit_assert.svh"
module lzd_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tvalid,
    output logic                               o_tready,
    input  wire logic [lzd_pkg::IN_TDATA_W-1:0] i_tdata,
    input  wire logic                          i_tuser,
    output logic                               o_valid,
    output lzd_pkg::t_token                    o_tok,
    input  wire logic                          i_pop
);
    import lzd_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_token          r_q [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr, r_rd;
    logic [CNTW-1:0] r_cnt;
    logic            push;
    t_token          tok_in;

    assign o_tready = (r_cnt != CNTW'(QUEUE_DEPTH));
    assign push     = i_tvalid && o_tready;
    assign o_valid  = (r_cnt != '0);
    assign o_tok    = r_q[r_rd];

    always_comb begin
        tok_in.start_new    = i_tuser;
        tok_in.phrase_index = i_tdata[IDX_W-1:0];
        tok_in.literal      = i_tdata[IDX_W +: BYTE_W];
        tok_in.idx_zero     = (i_tdata[IDX_W-1:0] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= tok_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `LZD_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && r_cnt == '0)
    `LZD_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNTW'(QUEUE_DEPTH))
    `LZD_ASSERT(a_cnt_hold, i_clk, i_rst_n, !push && !i_pop |=> $stable(r_cnt))
endmodule
`default_nettype wire

@@ src/lzd_back.sv @@
// Token execution: dictionary, chain walk, reverse stack and output register.
// Depends on lzd_pkg and the assertion macro header.
`default_nettype none
`include "lz78_phrase_decoder_unit_assert.svh"
module lzd_back #(
    parameter int DICT_ENTRIES = lzd_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_PHRASE   = lzd_pkg::MAX_PHRASE_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire lzd_pkg::t_token            i_tok,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  wire logic                       i_m_tready,
    output logic [lzd_pkg::BYTE_W-1:0]      o_m_tdata,
    output logic                            o_m_tlast,
    output logic [lzd_pkg::ST_W-1:0]        o_m_tuser
);
    import lzd_pkg::*;

    localparam int CW = $clog2(DICT_ENTRIES + 1);
    localparam int AW = $clog2(DICT_ENTRIES);
    localparam int SW = (MAX_PHRASE > 2) ? $clog2(MAX_PHRASE) : 1;

    typedef struct packed {
        logic [CW-1:0]     parent;
        logic [BYTE_W-1:0] lit;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_WALK, S_PREP, S_OUT, S_LIT, S_ERR
    } t_state;

    t_entry            r_dict [DICT_ENTRIES];
    logic [BYTE_W-1:0] r_stack [MAX_PHRASE];
    t_entry            r_dq;
    logic [BYTE_W-1:0] r_sq;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [ST_W-1:0]   r_err, n_err;
    t_token            r_tok, n_tok;
    logic [LEN_W-1:0]  r_plen, n_plen;
    logic [SW-1:0]     r_depth, n_depth;
    logic [SW-1:0]     r_ptr, n_ptr;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_olast, n_olast;
    logic [ST_W-1:0]   r_ostat, n_ostat;

    logic              slot_free;
    logic [CW-1:0]     cnt_eff;
    logic [ST_W-1:0]   err_eff;
    logic              dict_re, dict_we, stk_re, stk_we;
    logic [AW-1:0]     dict_raddr, dict_waddr;
    t_entry            dict_wdata;
    logic [SW-1:0]     stk_raddr, stk_waddr;

    assign slot_free  = !r_ovalid || i_m_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_ostat;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_err      = r_err;
        n_tok      = r_tok;
        n_plen     = r_plen;
        n_depth    = r_depth;
        n_ptr      = r_ptr;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_obyte    = r_obyte;
        n_olast    = r_olast;
        n_ostat    = r_ostat;
        o_pop      = 1'b0;
        dict_re    = 1'b0;
        dict_raddr = '0;
        dict_we    = 1'b0;
        dict_waddr = AW'(r_count);
        dict_wdata = '{parent: CW'(r_tok.phrase_index), lit: r_tok.literal,
                       len: r_plen + LEN_W'(1)};
        stk_we     = 1'b0;
        stk_waddr  = r_depth;
        stk_re     = 1'b0;
        stk_raddr  = r_ptr - 1'b1;
        cnt_eff    = i_tok.start_new ? '0 : r_count;
        err_eff    = i_tok.start_new ? ST_OK : r_err;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_tok   = i_tok;
                    n_count = cnt_eff;
                    n_err   = err_eff;
                    n_depth = '0;
                    if (err_eff != ST_OK) begin
                        n_state = S_ERR;
                    end else if ({1'b0, i_tok.phrase_index} > (IDX_W + 1)'(cnt_eff)) begin
                        n_err   = ST_BAD_INDEX;
                        n_state = S_ERR;
                    end else if (cnt_eff >= CW'(DICT_ENTRIES)) begin
                        n_err   = ST_FULL;
                        n_state = S_ERR;
                    end else if (i_tok.idx_zero) begin
                        n_plen  = '0;
                        n_state = S_LIT;
                    end else begin
                        dict_re    = 1'b1;
                        dict_raddr = AW'(i_tok.phrase_index - 1'b1);
                        n_state    = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (r_dq.len >= LEN_W'(MAX_PHRASE)) begin
                    n_err   = ST_TOO_LONG;
                    n_state = S_ERR;
                end else begin
                    n_plen  = r_dq.len;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                stk_we = 1'b1;
                if (LEN_W'(r_depth) + LEN_W'(1) == r_plen) begin
                    n_ptr   = SW'(r_plen);
                    n_state = S_PREP;
                end else begin
                    n_depth    = r_depth + 1'b1;
                    dict_re    = 1'b1;
                    dict_raddr = AW'(r_dq.parent - 1'b1);
                end
            end
            S_PREP: begin
                stk_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_sq;
                    n_olast  = 1'b0;
                    n_ostat  = ST_OK;
                    n_ptr    = r_ptr - 1'b1;
                    if (r_ptr == SW'(1)) begin
                        n_state = S_LIT;
                    end else begin
                        stk_re    = 1'b1;
                        stk_raddr = r_ptr - 1'b1 - 1'b1;
                    end
                end
            end
            S_LIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = r_tok.literal;
                    n_olast  = 1'b1;
                    n_ostat  = ST_OK;
                    dict_we  = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = '0;
                    n_olast  = 1'b1;
                    n_ostat  = r_err;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_dict[dict_waddr] <= dict_wdata;
        end
        if (dict_re) begin
            r_dq <= r_dict[dict_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= r_dq.lit;
        end
        if (stk_re) begin
            r_sq <= r_stack[stk_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_err    <= ST_OK;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
        r_tok   <= n_tok;
        r_plen  <= n_plen;
        r_depth <= n_depth;
        r_ptr   <= n_ptr;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
        r_ostat <= n_ostat;
    end

    `LZD_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DICT_ENTRIES))
    `LZD_ASSERT(a_err_item, i_clk, i_rst_n, o_m_tvalid && o_m_tuser != ST_OK |-> o_m_tlast && o_m_tdata == '0)
    `LZD_ASSERT(a_out_ptr, i_clk, i_rst_n, r_state == S_OUT |-> r_ptr != '0)
    `LZD_ASSERT(a_append, i_clk, i_rst_n, r_state == S_LIT && slot_free |=> r_count == CW'($past(r_count) + 1'b1))
endmodule
`default_nettype wire

@@ src/lz78_phrase_decoder_unit.sv @@
// LZ78 token decoder. One input item is a token {start_new in tuser; phrase_index in
// tdata[15:0], literal in tdata[23:16]}; it yields the prefix phrase bytes and the
// literal, one byte per output item, tlast on the final one, tuser the status
// (0 ok, 1 bad index, 2 dictionary full, 3 phrase too long; sticky until start_new,
// one item per failing token). A two-entry queue takes tokens while the back end
// works. For a prefix of length L the single dictionary read port walks the parent
// chain one entry per cycle, then the reverse stack is read out one byte per cycle
// while the output accepts items. The dictionary has no clearing pass; the entry
// count bounds every read.
// Depends on lzd_pkg, lzd_front and lzd_back.
`default_nettype none
module lz78_phrase_decoder_unit #(
    parameter int DICT_ENTRIES = lzd_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_PHRASE   = lzd_pkg::MAX_PHRASE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [lzd_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // phrase_index, literal
    input  wire logic                          s_axis_tuser,  // start_new
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [lzd_pkg::BYTE_W-1:0]         m_axis_tdata,  // out_byte
    output logic                               m_axis_tlast,
    output logic [lzd_pkg::ST_W-1:0]           m_axis_tuser   // status
);
    import lzd_pkg::*;

    logic   q_valid;
    logic   q_pop;
    t_token q_tok;

    lzd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_valid  (q_valid),
        .o_tok    (q_tok),
        .i_pop    (q_pop)
    );

    lzd_back #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .MAX_PHRASE   (MAX_PHRASE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_tok      (q_tok),
        .o_pop      (q_pop),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );
endmodule
`default_nettype wire
